// ----- sv/hevc_open_gop_nal_scanner_defines.svh -----
// Assertion macros used by the checker file.
`ifndef HEVC_OPEN_GOP_NAL_SCANNER_DEFINES_SVH
`define HEVC_OPEN_GOP_NAL_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define HOGNS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define HOGNS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/hogns_pkg.sv -----
`default_nettype none

package hogns_pkg;

  localparam int POSITION_WIDTH_DEF = 24;
  localparam int CFG_W = 3;
  localparam int SIZE_W = 24;
  localparam int LEN_W = 32;
  localparam int TYPE_W = 6;

  localparam logic [CFG_W-1:0] PREFIX_RESET = 3'd4;
  localparam logic [CFG_W-1:0] PREFIX_MIN = 3'd1;
  localparam logic [CFG_W-1:0] PREFIX_MAX = 3'd4;

  // Unit types that mark an open GOP
  localparam logic [TYPE_W-1:0] NUT_RASL_N = 6'd8;
  localparam logic [TYPE_W-1:0] NUT_RASL_R = 6'd9;
  localparam logic [TYPE_W-1:0] NUT_BLA_W_LP = 6'd16;
  localparam logic [TYPE_W-1:0] NUT_BLA_W_RADL = 6'd17;
  localparam logic [TYPE_W-1:0] NUT_BLA_N_LP = 6'd18;
  localparam logic [TYPE_W-1:0] NUT_CRA = 6'd21;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_TYPE   = 2'd1,
    PH_SKIP   = 2'd2,
    PH_STOP   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic [SIZE_W-1:0] packet_size;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic              open_gop_found;
    logic [TYPE_W-1:0] unit_type;
  } out_item_t;

  function automatic logic is_open_gop(logic [TYPE_W-1:0] t);
    return t inside {NUT_RASL_N, NUT_RASL_R, NUT_BLA_W_LP, NUT_BLA_W_RADL,
                     NUT_BLA_N_LP, NUT_CRA};
  endfunction

  // Clamp the configured prefix width to 1..4
  function automatic logic [CFG_W-1:0] prefix_width(logic [CFG_W-1:0] c);
    logic [CFG_W-1:0] w;
    w = c;
    if (c < PREFIX_MIN) w = PREFIX_MIN;
    if (c > PREFIX_MAX) w = PREFIX_MAX;
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- sv/hevc_open_gop_nal_scanner.sv -----
// Channel   Direction  Handshake              Carries
// in_*      input      in_valid / in_stall    one packet byte, packet size, last flag
// out_*     output     out_valid / out_stall  open-GOP flag and unit type
// cfg_*     input      cfg_valid / cfg_ready  length prefix width (1 to 4 bytes)
//
// One byte is taken every cycle while in_stall is low; a byte's request passes from the
// input register through the scan update into the result register.
// The result appears only for a byte with last_byte set; other bytes give none.
// rst_n is synchronous and active low; it clears the scan and the prefix width to 4.
// in_stall rises only while a result is held under out_stall and a byte waits behind it.
// cfg_ready is always high; a new prefix width applies from the next byte scanned.
`default_nettype none

module hevc_open_gop_nal_scanner #(
  parameter int POSITION_WIDTH = hogns_pkg::POSITION_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire hogns_pkg::in_item_t         in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output hogns_pkg::out_item_t             out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [hogns_pkg::CFG_W-1:0] cfg_data
);

  logic                          stg_valid;
  hogns_pkg::in_item_t           stg_item;
  logic                          advance;
  logic [hogns_pkg::CFG_W-1:0]   prefix_cfg_r;

  // Configuration request: take it at once, no back-pressure
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_cfg_r <= hogns_pkg::PREFIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      prefix_cfg_r <= cfg_data;
    end
  end

  // Input register: hold each byte request until the scan can take it
  hogns_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .advance   (advance),
    .in_stall  (in_stall),
    .stg_valid (stg_valid),
    .stg_item  (stg_item)
  );

  // Scan update and result register; advance drops only while a result is stuck
  hogns_core #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .stg_valid  (stg_valid),
    .stg_item   (stg_item),
    .prefix_cfg (prefix_cfg_r),
    .out_stall  (out_stall),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// ----- sv/hogns_in_reg.sv -----
`default_nettype none

module hogns_in_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire hogns_pkg::in_item_t in_data,
  input  wire logic                advance,
  output logic                     in_stall,
  output logic                     stg_valid,
  output hogns_pkg::in_item_t      stg_item
);

  logic                stg_valid_r;
  hogns_pkg::in_item_t stg_item_r;

  // Hold the byte only while it cannot move on
  assign in_stall = stg_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (!in_stall) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      stg_item_r <= in_data;
    end
  end

  assign stg_valid = stg_valid_r;
  assign stg_item  = stg_item_r;

endmodule

`default_nettype wire

// ----- sv/hogns_core.sv -----
`default_nettype none

module hogns_core #(
  parameter int POSITION_WIDTH = hogns_pkg::POSITION_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        stg_valid,
  input  wire hogns_pkg::in_item_t         stg_item,
  input  wire logic [hogns_pkg::CFG_W-1:0] prefix_cfg,
  input  wire logic                        out_stall,
  output logic                             advance,
  output logic                             out_valid,
  output hogns_pkg::out_item_t             out_data
);

  localparam int SUM_W = 34;
  localparam int SW = hogns_pkg::SIZE_W;
  localparam int LW = hogns_pkg::LEN_W;
  localparam int TW = hogns_pkg::TYPE_W;

  hogns_pkg::phase_t         phase_r, phase_nxt;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic [LW-1:0]             acc_r, acc_nxt;
  logic [1:0]                hbs_r, hbs_nxt;
  logic [SW-1:0]             left_r, left_nxt;
  logic                      found_r, found_nxt;
  logic [TW-1:0]             ftype_r, ftype_nxt;
  logic                      out_valid_r, out_valid_nxt;
  hogns_pkg::out_item_t      out_data_r, out_data_nxt;

  logic                      fire;
  logic [hogns_pkg::CFG_W-1:0] w;
  logic [LW-1:0]             acc_v;
  logic [SUM_W-1:0]          pos_ext, size_ext;
  logic [TW-1:0]             t;

  assign advance = !(out_valid_r && out_stall);
  assign fire    = stg_valid && advance;

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    acc_nxt       = acc_r;
    hbs_nxt       = hbs_r;
    left_nxt      = left_r;
    found_nxt     = found_r;
    ftype_nxt     = ftype_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    w        = hogns_pkg::prefix_width(prefix_cfg);
    pos_ext  = SUM_W'(pos_r);
    size_ext = SUM_W'(stg_item.packet_size);
    acc_v    = (hbs_r == 2'd0) ? LW'(stg_item.data_byte)
                               : {acc_r[LW-9:0], stg_item.data_byte};
    t        = stg_item.data_byte[6:1];

    if (advance) begin
      out_valid_nxt = 1'b0;
    end

    if (fire) begin
      unique case (phase_r)
        hogns_pkg::PH_HEADER: begin
          if (hbs_r == 2'd0 && !(pos_ext + SUM_W'(w) < size_ext)) begin
            phase_nxt = hogns_pkg::PH_STOP;
          end else begin
            acc_nxt = acc_v;
            if ({1'b0, hbs_r} + 3'd1 >= w) begin
              hbs_nxt = 2'd0;
              if (acc_v == '0 || acc_v[LW-1] ||
                  pos_ext + SUM_W'(1) + SUM_W'(acc_v) > size_ext) begin
                phase_nxt = hogns_pkg::PH_STOP;
              end else begin
                phase_nxt = hogns_pkg::PH_TYPE;
              end
            end else begin
              hbs_nxt = hbs_r + 2'd1;
            end
          end
        end
        hogns_pkg::PH_TYPE: begin
          if (hogns_pkg::is_open_gop(t)) begin
            found_nxt = 1'b1;
            ftype_nxt = t;
            phase_nxt = hogns_pkg::PH_STOP;
          end else begin
            left_nxt  = acc_r[SW-1:0] - SW'(1);
            phase_nxt = (left_nxt != '0) ? hogns_pkg::PH_SKIP : hogns_pkg::PH_HEADER;
          end
        end
        hogns_pkg::PH_SKIP: begin
          left_nxt = left_r - SW'(1);
          if (left_nxt == '0) phase_nxt = hogns_pkg::PH_HEADER;
        end
        hogns_pkg::PH_STOP: begin
        end
      endcase

      pos_nxt = pos_r + POSITION_WIDTH'(1);

      // Report on the final byte, then clear the scan
      if (stg_item.last_byte) begin
        out_valid_nxt               = 1'b1;
        out_data_nxt.open_gop_found = found_nxt;
        out_data_nxt.unit_type      = ftype_nxt;
        phase_nxt = hogns_pkg::PH_HEADER;
        pos_nxt   = '0;
        acc_nxt   = '0;
        hbs_nxt   = 2'd0;
        left_nxt  = '0;
        found_nxt = 1'b0;
        ftype_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= hogns_pkg::PH_HEADER;
      pos_r       <= '0;
      acc_r       <= '0;
      hbs_r       <= 2'd0;
      left_r      <= '0;
      found_r     <= 1'b0;
      ftype_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      acc_r       <= acc_nxt;
      hbs_r       <= hbs_nxt;
      left_r      <= left_nxt;
      found_r     <= found_nxt;
      ftype_r     <= ftype_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- sv/hogns_checker.sv -----
`default_nettype none
`include "hevc_open_gop_nal_scanner_defines.svh"

module hogns_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire hogns_pkg::out_item_t out_data
);

  `HOGNS_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall, "in_stall without held result")
  `HOGNS_ASSERT_IMP(a_none_zero, out_valid && !out_data.open_gop_found, out_data.unit_type == '0, "unit_type not zero when none found")
  `HOGNS_ASSERT_IMP(a_found_type, out_valid && out_data.open_gop_found, hogns_pkg::is_open_gop(out_data.unit_type), "found type is not open-GOP")
  `HOGNS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind hevc_open_gop_nal_scanner hogns_checker u_hogns_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ----- test/hevc_open_gop_nal_scanner_test.sv -----
module hevc_open_gop_nal_scanner_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hogns_pkg::*;

  // Let a byte clear the input register and the scan update before a width write.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DIR_ROWS = 31;

  // Prefix widths for the first phases: both extremes, the two between, then the ones that clamp.
  localparam logic [CFG_W-1:0] WIDTH_SWEEP [8] = '{3'd1, 3'd4, 3'd2, 3'd3,
                                                   3'd0, 3'd7, 3'd5, 3'd6};
  localparam logic [TYPE_W-1:0] GOP_TYPES [6] = '{NUT_RASL_N, NUT_RASL_R, NUT_BLA_W_LP,
                                                  NUT_BLA_W_RADL, NUT_BLA_N_LP, NUT_CRA};

  typedef enum logic [0:0] {
    ROW_BYTE = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  // One row of the directed table: a byte request or a width write.
  // Where known is set, exp_found and exp_type give the verdict outright.
  typedef struct packed {
    row_kind_t         kind;
    logic [CFG_W-1:0]  width_val;
    logic [7:0]        data;
    logic [SIZE_W-1:0] size;
    logic              last;
    logic              known;
    logic              exp_found;
    logic [TYPE_W-1:0] exp_type;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  hevc_open_gop_nal_scanner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Scanner mirror: its own copy of the width register and of the scan state.
  logic [CFG_W-1:0]  prefix_cfg;
  phase_t            scan_ph;
  logic [23:0]       scan_pos;
  logic [LEN_W-1:0]  len_acc;
  logic [1:0]        hdr_seen;
  logic [SIZE_W-1:0] skip_left;
  logic              gop_seen;
  logic [TYPE_W-1:0] gop_type;

  out_item_t         verdicts_due[$];
  int unsigned       mismatches = 0;
  int unsigned       bytes_sent = 0;
  int unsigned       verdicts_sent = 0;
  int unsigned       cycle_count = 0;
  int unsigned       burst_left = 0;
  bit                hold_off_req = 1'b0;

  logic [7:0]        pkt_bytes[$];
  logic [SIZE_W-1:0] pkt_size;
  stim_row_t         dir_rows [DIR_ROWS];

  // Width 0 behaves as 1, anything above 4 as 4.
  function automatic int unsigned prefix_span(logic [CFG_W-1:0] c);
    if (c < PREFIX_MIN) return PREFIX_MIN;
    if (c > PREFIX_MAX) return PREFIX_MAX;
    return c;
  endfunction

  function automatic bit opens_gop(logic [TYPE_W-1:0] t);
    case (t)
      NUT_RASL_N, NUT_RASL_R, NUT_BLA_W_LP, NUT_BLA_W_RADL, NUT_BLA_N_LP, NUT_CRA: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic wipe_scan();
    scan_ph = PH_HEADER;
    scan_pos = '0;
    len_acc = '0;
    hdr_seen = '0;
    skip_left = '0;
    gop_seen = 1'b0;
    gop_type = '0;
  endtask

  // Advance the mirror by one accepted byte; on the last byte hand back the verdict.
  task automatic track_scan(input in_item_t it, output bit done, output out_item_t verdict);
    longint unsigned w;
    longint unsigned at;
    longint unsigned sz;
    longint unsigned ln;
    logic [TYPE_W-1:0] ty;
    w = prefix_span(prefix_cfg);
    at = scan_pos;
    sz = it.packet_size;
    done = 1'b0;
    verdict = '0;
    case (scan_ph)
      PH_HEADER: begin
        // A prefix is only taken up if a byte of the unit can follow it.
        if (hdr_seen == 2'd0 && !(at + w < sz)) begin
          scan_ph = PH_STOP;
        end else begin
          len_acc = (hdr_seen == 2'd0) ? {24'd0, it.data_byte} : {len_acc[23:0], it.data_byte};
          if (longint'(hdr_seen) + 1 >= w) begin
            ln = len_acc;
            hdr_seen = 2'd0;
            if (ln == 0 || len_acc[31] || at + 1 + ln > sz) scan_ph = PH_STOP;
            else scan_ph = PH_TYPE;
          end else begin
            hdr_seen = hdr_seen + 2'd1;
          end
        end
      end
      PH_TYPE: begin
        ty = it.data_byte[6:1];
        if (opens_gop(ty)) begin
          gop_seen = 1'b1;
          gop_type = ty;
          scan_ph = PH_STOP;
        end else begin
          skip_left = len_acc[SIZE_W-1:0] - 24'd1;
          scan_ph = (skip_left != '0) ? PH_SKIP : PH_HEADER;
        end
      end
      PH_SKIP: begin
        skip_left = skip_left - 24'd1;
        if (skip_left == '0) scan_ph = PH_HEADER;
      end
      default: ;
    endcase
    scan_pos = scan_pos + 24'd1;
    if (it.last_byte) begin
      done = 1'b1;
      verdict.open_gop_found = gop_seen;
      verdict.unit_type = gop_type;
      wipe_scan();
    end
  endtask

  // Offer one byte request and hold it until taken; then book its verdict, if any.
  task automatic send_byte(input in_item_t it, input bit known, input out_item_t known_exp);
    bit done;
    out_item_t verdict;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    track_scan(it, done, verdict);
    bytes_sent++;
    if (done) begin
      verdicts_due.push_back(known ? known_exp : verdict);
      verdicts_sent++;
    end
  endtask

  // Burst pacing: drop valid for a random gap once the current burst runs out.
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 12);
    end
  endtask

  // Write the prefix width only once the block has drained.
  task automatic set_width(input logic [CFG_W-1:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    prefix_cfg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Build one packet into pkt_bytes / pkt_size: half the time well-formed units with
  // random content, the rest with a bent size, a spoilt prefix, an early or
  // missing last byte, one huge unit, or plain noise.
  task automatic compose_packet();
    int unsigned w;
    int unsigned mode;
    int unsigned units;
    int unsigned ulen;
    int unsigned cap;
    int unsigned cut;
    logic [TYPE_W-1:0] ty;
    pkt_bytes.delete();
    w = prefix_span(prefix_cfg);
    mode = $urandom_range(0, 11);
    if (mode == 11) begin
      repeat ($urandom_range(1, 12)) pkt_bytes.push_back(8'($urandom));
      pkt_size = $urandom_range(0, 1) ? 24'($urandom_range(1, 16))
                                      : 24'($urandom_range(1, 24'hFFFFFF));
      return;
    end
    if (mode == 10) begin
      // Long unit in a maximum-size packet; the skip is cut off by last_byte.
      cap = (w >= 3) ? 32'hFFFFF0 : (32'd1 << (8 * w)) - 1;
      ulen = $urandom_range(1, cap);
      for (int k = w; k > 0; k--) pkt_bytes.push_back(8'(ulen >> (8 * (k - 1))));
      pkt_bytes.push_back(8'($urandom));
      repeat ($urandom_range(0, 10)) pkt_bytes.push_back(8'($urandom));
      pkt_size = 24'hFFFFFF;
      return;
    end
    units = $urandom_range(1, 4);
    repeat (units) begin
      ulen = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      ty = ($urandom_range(0, 2) == 0) ? GOP_TYPES[$urandom_range(0, 5)] : 6'($urandom);
      for (int k = w; k > 0; k--) pkt_bytes.push_back(8'(ulen >> (8 * (k - 1))));
      pkt_bytes.push_back({1'($urandom), ty, 1'($urandom)});
      repeat (ulen - 1) pkt_bytes.push_back(8'($urandom));
    end
    pkt_size = 24'(pkt_bytes.size());
    case (mode)
      6: pkt_size = pkt_size + 24'($urandom_range(1, 300));
      7: if (pkt_size > 1) pkt_size = 24'($urandom_range(1, pkt_size - 1));
      8: begin
        if ($urandom_range(0, 1)) begin
          for (int k = 0; k < w; k++) pkt_bytes[k] = 8'h00;
        end else begin
          pkt_bytes[0] = 8'($urandom);
        end
      end
      9: begin
        if ($urandom_range(0, 1) && pkt_bytes.size() > 1) begin
          cut = $urandom_range(1, pkt_bytes.size() - 1);
          while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
        end else begin
          repeat ($urandom_range(1, 5)) pkt_bytes.push_back(8'($urandom));
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_packet();
    in_item_t it;
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      it.data_byte = pkt_bytes[i];
      it.packet_size = pkt_size;
      it.last_byte = (i == pkt_bytes.size() - 1);
      send_byte(it, 1'b0, '0);
      pace();
    end
  endtask

  function automatic stim_row_t plain_row(logic [7:0] d, logic [SIZE_W-1:0] sz, logic lst);
    return '{ROW_BYTE, 3'd0, d, sz, lst, 1'b0, 1'b0, 6'd0};
  endfunction

  function automatic stim_row_t known_row(logic [7:0] d, logic [SIZE_W-1:0] sz, logic lst,
                                          logic f, logic [TYPE_W-1:0] t);
    return '{ROW_BYTE, 3'd0, d, sz, lst, 1'b1, f, t};
  endfunction

  function automatic stim_row_t width_row(logic [CFG_W-1:0] v);
    return '{ROW_CFG, v, 8'd0, 24'd0, 1'b0, 1'b0, 1'b0, 6'd0};
  endfunction

  // Run limit: anything still going by now has hung.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Check every accepted verdict against the oldest one booked.
  always @(posedge clk) begin
    out_item_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: verdict with none due: found=%0b type=%0d", $time,
                 out_data.open_gop_found, out_data.unit_type);
        mismatches++;
      end else begin
        due = verdicts_due.pop_front();
        if (out_data.open_gop_found !== due.open_gop_found) begin
          $display("%0t: open_gop_found expected %0b actual %0b", $time,
                   due.open_gop_found, out_data.open_gop_found);
          mismatches++;
        end
        if (out_data.unit_type !== due.unit_type) begin
          $display("%0t: unit_type expected %0d actual %0d", $time,
                   due.unit_type, out_data.unit_type);
          mismatches++;
        end
      end
    end
  end

  // Receiver: change stall mode after each random span (none, light, heavy,
  // periodic), and once, on request, hold off for a long stretch.
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    wait (rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        if (hold_off_req) begin
          out_stall <= 1'b1;
          repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
          hold_off_req = 1'b0;
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((k % 5) < 2);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    in_item_t it;
    out_item_t known_exp;
    int unsigned phase_no;
    logic [CFG_W-1:0] next_w;

    prefix_cfg = PREFIX_RESET;
    wipe_scan();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    dir_rows = '{
      // Reset width of four: one CRA unit fills the packet.
      plain_row(8'h00, 24'd5, 1'b0), plain_row(8'h00, 24'd5, 1'b0),
      plain_row(8'h00, 24'd5, 1'b0), plain_row(8'h01, 24'd5, 1'b0),
      known_row({1'b0, NUT_CRA, 1'b0}, 24'd5, 1'b1, 1'b1, NUT_CRA),
      // Length with its top bit set stops the scan before the RASL byte.
      plain_row(8'h80, 24'd5, 1'b0), plain_row(8'h00, 24'd5, 1'b0),
      plain_row(8'h00, 24'd5, 1'b0), plain_row(8'h01, 24'd5, 1'b0),
      known_row({1'b0, NUT_RASL_R, 1'b1}, 24'd5, 1'b1, 1'b0, 6'd0),
      // Width zero acts as one; a zero length stops the scan.
      width_row(3'd0),
      plain_row(8'h00, 24'd2, 1'b0),
      known_row(8'hFF, 24'd2, 1'b1, 1'b0, 6'd0),
      // Largest packet size, cut short by last_byte after a BLA unit.
      plain_row(8'h03, 24'hFFFFFF, 1'b0),
      known_row({1'b0, NUT_BLA_W_LP, 1'b0}, 24'hFFFFFF, 1'b1, 1'b1, NUT_BLA_W_LP),
      // No room for a unit after the prefix; the byte past the size is ignored.
      plain_row(8'h05, 24'd1, 1'b0),
      known_row({1'b1, NUT_CRA, 1'b1}, 24'd1, 1'b1, 1'b0, 6'd0),
      // Skip a two-byte unit, then hit a one-byte RASL unit.
      plain_row(8'h02, 24'd5, 1'b0), plain_row(8'h02, 24'd5, 1'b0),
      plain_row(8'hAB, 24'd5, 1'b0), plain_row(8'h01, 24'd5, 1'b0),
      plain_row({1'b0, NUT_RASL_N, 1'b1}, 24'd5, 1'b1),
      // Unit running past the packet end.
      plain_row(8'h05, 24'd3, 1'b0), plain_row({1'b0, NUT_CRA, 1'b0}, 24'd3, 1'b0),
      known_row({1'b0, NUT_CRA, 1'b0}, 24'd3, 1'b1, 1'b0, 6'd0),
      // Width drops from two to one halfway through a prefix; state is kept.
      width_row(3'd2),
      plain_row(8'h00, 24'd4, 1'b0),
      width_row(3'd1),
      plain_row(8'h01, 24'd4, 1'b0), plain_row({1'b0, NUT_CRA, 1'b0}, 24'd4, 1'b0),
      plain_row(8'h77, 24'd4, 1'b1)
    };

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        set_width(dir_rows[i].width_val);
      end else begin
        it.data_byte = dir_rows[i].data;
        it.packet_size = dir_rows[i].size;
        it.last_byte = dir_rows[i].last;
        known_exp.open_gop_found = dir_rows[i].exp_found;
        known_exp.unit_type = dir_rows[i].exp_type;
        send_byte(it, dir_rows[i].known, known_exp);
        pace();
      end
    end

    // Random phases, each at its own prefix width, written while idle.
    phase_no = 0;
    while (phase_no < 8 || bytes_sent < 1500 || verdicts_sent < 60) begin
      next_w = (phase_no < 8) ? WIDTH_SWEEP[phase_no] : 3'($urandom_range(0, 7));
      set_width(next_w);
      if (phase_no == 3) begin
        // Back-to-back one-byte packets while the receiver holds off: fill the block.
        hold_off_req = 1'b1;
        repeat (80) begin
          it.data_byte = 8'($urandom);
          it.packet_size = 24'($urandom_range(1, 3));
          it.last_byte = 1'b1;
          send_byte(it, 1'b0, '0);
        end
      end
      repeat ($urandom_range(6, 16)) begin
        compose_packet();
        send_packet();
      end
      phase_no++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
